// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the RTL. Synthesis builds see empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// A property that must hold at every rising edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// A condition that must never be seen at a rising edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

// ----- hdl/cmc_pkg.sv -----
`timescale 1ns / 1ps

package cmc_pkg;

    localparam int LIGHT_W = 10;
    localparam int THR_W   = 11;
    localparam int DUTY_W  = 10;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 11;

    // Motor drive codes.
    localparam logic [1:0] DIR_STOP  = 2'd0;
    localparam logic [1:0] DIR_OPEN  = 2'd1;
    localparam logic [1:0] DIR_CLOSE = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_OPEN_THR  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_THR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_DUTY = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW_DUTY = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MID_DUTY  = 3'd4;

    // Reset values of the configuration registers.
    localparam logic [THR_W-1:0]  OPEN_THR_RST  = 11'd1500;
    localparam logic [THR_W-1:0]  CLOSE_THR_RST = 11'd1000;
    localparam logic [DUTY_W-1:0] FULL_DUTY_RST = 10'd200;
    localparam logic [DUTY_W-1:0] SLOW_DUTY_RST = 10'd100;
    localparam logic [DUTY_W-1:0] MID_DUTY_RST  = 10'd50;

    typedef struct packed {
        logic [THR_W-1:0]  open_thr;
        logic [THR_W-1:0]  close_thr;
        logic [DUTY_W-1:0] full_duty;
        logic [DUTY_W-1:0] slow_duty;
        logic [DUTY_W-1:0] middle_duty;
    } cfg_t;

    typedef struct packed {
        logic               op;
        logic [LIGHT_W-1:0] light_level;
        logic               mode_button;
        logic               closed_switch;
        logic               middle_switch;
        logic               open_switch;
        logic               close_button;
        logic               open_button;
    } item_t;

    typedef struct packed {
        logic              is_closed;
        logic              is_open;
        logic              past_middle;
        logic              moving_open;
        logic              moving_closed;
        logic              manual_flag;
        logic [1:0]        drive_dir;
        logic [DUTY_W-1:0] duty_value;
        logic              closed_led;
        logic              open_led;
        logic              manual_led;
        logic              blink_phase;
    } ctrl_state_t;

endpackage

// ----- hdl/curtain_motor_controller.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Curtain motor controller. Each input word is either a poll pass (tuser low) carrying a
// light sample, the limit and middle switches and the buttons, or a blink tick (tuser high).
// Every word yields exactly one result word that shows the motor drive, duty and LEDs after
// it. It takes one word per cycle unless the output stalls: a word is registered on entry,
// the control update is a short chain of flag tests, the result sits in an output register.
// The user writes thresholds and duties through the cfg port while idle; not enforced here.
module curtain_motor_controller (
    input  logic                              clk,
    input  logic                              rst_n,
    // s_tdata: light_level[9:0], mode_button, closed_switch, middle_switch,
    // open_switch, close_button, open_button
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [15:0]                       s_tdata,
    // s_tuser: op (0 poll pass, 1 blink tick)
    input  logic                              s_tuser,
    // m_tdata: motor_dir[1:0], duty[9:0], led_closed, led_open, led_manual, manual_mode
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [15:0]                       m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [cmc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cmc_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import cmc_pkg::*;

    cfg_t        cfg_reg;
    item_t       item_reg;
    logic        item_valid_reg;
    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    ctrl_state_t out_reg;
    logic        out_valid_reg;
    logic        advance;

    assign cfg_ready = 1'b1;
    assign advance   = item_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !item_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.open_thr    <= OPEN_THR_RST;
            cfg_reg.close_thr   <= CLOSE_THR_RST;
            cfg_reg.full_duty   <= FULL_DUTY_RST;
            cfg_reg.slow_duty   <= SLOW_DUTY_RST;
            cfg_reg.middle_duty <= MID_DUTY_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_OPEN_THR:  cfg_reg.open_thr    <= cfg_data;
                CFG_CLOSE_THR: cfg_reg.close_thr   <= cfg_data;
                CFG_FULL_DUTY: cfg_reg.full_duty   <= cfg_data[DUTY_W-1:0];
                CFG_SLOW_DUTY: cfg_reg.slow_duty   <= cfg_data[DUTY_W-1:0];
                CFG_MID_DUTY:  cfg_reg.middle_duty <= cfg_data[DUTY_W-1:0];
                default: ;
            endcase
        end
    end

    // Input stage: holds one word until the output register can take its result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            item_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg.op            <= s_tuser;
            item_reg.light_level   <= s_tdata[9:0];
            item_reg.mode_button   <= s_tdata[10];
            item_reg.closed_switch <= s_tdata[11];
            item_reg.middle_switch <= s_tdata[12];
            item_reg.open_switch   <= s_tdata[13];
            item_reg.close_button  <= s_tdata[14];
            item_reg.open_button   <= s_tdata[15];
        end
    end

    cmc_step u_step (
        .cfg  (cfg_reg),
        .item (item_reg),
        .cur  (state_reg),
        .nxt  (state_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '{is_closed: 1'b0, is_open: 1'b1, past_middle: 1'b0,
                           moving_open: 1'b0, moving_closed: 1'b0, manual_flag: 1'b0,
                           drive_dir: DIR_STOP, duty_value: '0, closed_led: 1'b0,
                           open_led: 1'b0, manual_led: 1'b0, blink_phase: 1'b0};
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                state_reg <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= state_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.manual_flag, out_reg.manual_led, out_reg.open_led,
                       out_reg.closed_led, out_reg.duty_value, out_reg.drive_dir};

    // The moving flags always mirror the drive direction.
    `ASSERT_PROP(a_moving_matches_dir, clk, rst_n,
        (state_reg.moving_open == (state_reg.drive_dir == DIR_OPEN)) &&
        (state_reg.moving_closed == (state_reg.drive_dir == DIR_CLOSE)))
    // The curtain cannot be fully open and fully closed at once.
    `ASSERT_NEVER(a_open_and_closed, clk, rst_n, state_reg.is_open && state_reg.is_closed)
    // A moving curtain is at neither end.
    `ASSERT_PROP(a_moving_not_at_end, clk, rst_n,
        (state_reg.moving_open || state_reg.moving_closed) |->
        (!state_reg.is_open && !state_reg.is_closed))
    // The blink phase changes only when a word is processed.
    `ASSERT_PROP(a_blink_only_on_advance, clk, rst_n,
        !advance |=> $stable(state_reg.blink_phase))

endmodule

// ----- hdl/cmc_step.sv -----
`timescale 1ns / 1ps

module cmc_step (
    input  cmc_pkg::cfg_t        cfg,
    input  cmc_pkg::item_t       item,
    input  cmc_pkg::ctrl_state_t cur,
    output cmc_pkg::ctrl_state_t nxt
);
    import cmc_pkg::*;

    always_comb
    begin
        ctrl_state_t s;
        logic        go_open;
        logic        go_close;
        s = cur;
        go_open = 1'b0;
        go_close = 1'b0;

        if (item.op)
        begin
            s.blink_phase = ~s.blink_phase;
            if (s.moving_closed)
            begin
                s.closed_led = s.blink_phase;
            end
            if (s.moving_open)
            begin
                s.open_led = s.blink_phase;
            end
        end
        else
        begin
            if (item.mode_button)
            begin
                s.manual_flag = ~s.manual_flag;
                s.manual_led = ~s.manual_led;
            end

            // A limit switch only stops a motor that runs toward it.
            if (item.closed_switch && s.drive_dir == DIR_CLOSE)
            begin
                s.is_closed = 1'b1;
                s.past_middle = 1'b0;
                s.duty_value = '0;
                s.drive_dir = DIR_STOP;
                s.moving_open = 1'b0;
                s.moving_closed = 1'b0;
            end
            if (item.middle_switch)
            begin
                s.past_middle = 1'b1;
                s.duty_value = cfg.middle_duty;
            end
            if (item.open_switch && s.drive_dir == DIR_OPEN)
            begin
                s.is_open = 1'b1;
                s.past_middle = 1'b0;
                s.duty_value = '0;
                s.drive_dir = DIR_STOP;
                s.moving_open = 1'b0;
                s.moving_closed = 1'b0;
            end

            if (s.is_open)
            begin
                s.closed_led = 1'b0;
                s.open_led = 1'b1;
            end
            if (s.is_closed)
            begin
                s.closed_led = 1'b1;
                s.open_led = 1'b0;
            end
            if (!s.is_open && s.moving_closed)
            begin
                s.open_led = 1'b0;
            end
            if (!s.is_closed && s.moving_open)
            begin
                s.closed_led = 1'b0;
            end

            // Opening wins in automatic mode, closing wins in manual mode.
            if (!s.manual_flag)
            begin
                if ({1'b0, item.light_level} > cfg.open_thr && s.is_closed && !s.moving_open)
                begin
                    go_open = 1'b1;
                end
                else if ({1'b0, item.light_level} < cfg.close_thr && s.is_open
                         && !s.moving_closed)
                begin
                    go_close = 1'b1;
                end
            end
            else
            begin
                if (item.close_button && s.is_open)
                begin
                    go_close = 1'b1;
                end
                else if (item.open_button && s.is_closed)
                begin
                    go_open = 1'b1;
                end
            end

            if (go_open || go_close)
            begin
                s.drive_dir = go_open ? DIR_OPEN : DIR_CLOSE;
                s.duty_value = s.past_middle ? cfg.slow_duty : cfg.full_duty;
                s.is_closed = 1'b0;
                s.is_open = 1'b0;
                s.moving_open = go_open;
                s.moving_closed = go_close;
            end
        end

        nxt = s;
    end

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import cmc_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 4;
    localparam int PHASE_WORDS = 117;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST = CFG_MID_DUTY;

    // Tracks the controller state and the result words still owed by the block.
    class curtain_tracker;
        cfg_t         regs;
        ctrl_state_t  st;
        logic [15:0]  owed_words[$];
        int           errors;
        int           results_seen;

        function new();
            regs = '{OPEN_THR_RST, CLOSE_THR_RST, FULL_DUTY_RST, SLOW_DUTY_RST, MID_DUTY_RST};
            st = '0;
            st.is_open = 1'b1;
            st.drive_dir = DIR_STOP;
            errors = 0;
            results_seen = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_OPEN_THR:  regs.open_thr = data;
                CFG_CLOSE_THR: regs.close_thr = data;
                CFG_FULL_DUTY: regs.full_duty = data[DUTY_W-1:0];
                CFG_SLOW_DUTY: regs.slow_duty = data[DUTY_W-1:0];
                CFG_MID_DUTY:  regs.middle_duty = data[DUTY_W-1:0];
                default: ;
            endcase
        endfunction

        function void begin_move(logic [1:0] dir);
            st.drive_dir = dir;
            st.duty_value = st.past_middle ? regs.slow_duty : regs.full_duty;
            st.is_closed = 1'b0;
            st.is_open = 1'b0;
            st.moving_open = (dir == DIR_OPEN);
            st.moving_closed = (dir == DIR_CLOSE);
        endfunction

        function void halt_at(logic closed_end);
            if (closed_end)
                st.is_closed = 1'b1;
            else
                st.is_open = 1'b1;
            st.past_middle = 1'b0;
            st.duty_value = '0;
            st.drive_dir = DIR_STOP;
            st.moving_open = 1'b0;
            st.moving_closed = 1'b0;
        endfunction

        function logic [1:0] current_drive();
            return st.drive_dir;
        endfunction

        function int pending();
            return owed_words.size();
        endfunction

        function void take_word(logic op, logic [15:0] data);
            logic [LIGHT_W-1:0] light;
            light = data[LIGHT_W-1:0];
            if (op) begin
                st.blink_phase = ~st.blink_phase;
                if (st.moving_closed)
                    st.closed_led = st.blink_phase;
                if (st.moving_open)
                    st.open_led = st.blink_phase;
            end
            else begin
                if (data[10]) begin
                    st.manual_flag = ~st.manual_flag;
                    st.manual_led = ~st.manual_led;
                end
                if (data[11] && st.drive_dir == DIR_CLOSE)
                    halt_at(1'b1);
                if (data[12]) begin
                    st.past_middle = 1'b1;
                    st.duty_value = regs.middle_duty;
                end
                if (data[13] && st.drive_dir == DIR_OPEN)
                    halt_at(1'b0);
                if (st.is_open) begin
                    st.closed_led = 1'b0;
                    st.open_led = 1'b1;
                end
                if (st.is_closed) begin
                    st.closed_led = 1'b1;
                    st.open_led = 1'b0;
                end
                if (!st.is_open && st.moving_closed)
                    st.open_led = 1'b0;
                if (!st.is_closed && st.moving_open)
                    st.closed_led = 1'b0;
                if (!st.manual_flag) begin
                    if ({1'b0, light} > regs.open_thr && st.is_closed && !st.moving_open)
                        begin_move(DIR_OPEN);
                    else if ({1'b0, light} < regs.close_thr && st.is_open && !st.moving_closed)
                        begin_move(DIR_CLOSE);
                end
                else begin
                    if (data[14] && st.is_open)
                        begin_move(DIR_CLOSE);
                    else if (data[15] && st.is_closed)
                        begin_move(DIR_OPEN);
                end
            end
            owed_words.push_back({st.manual_flag, st.manual_led, st.open_led, st.closed_led,
                                  st.duty_value, st.drive_dir});
        endfunction

        function void compare_field(string name, int exp_val, int act_val);
            if (exp_val != act_val) begin
                $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
                errors++;
            end
        endfunction

        function void check_word(logic [15:0] data);
            logic [15:0] exp_word;
            results_seen++;
            if (owed_words.size() == 0) begin
                $error("result word 0x%04h arrived with nothing expected", data);
                errors++;
                return;
            end
            exp_word = owed_words.pop_front();
            compare_field("motor_dir", int'(exp_word[1:0]), int'(data[1:0]));
            compare_field("duty", int'(exp_word[11:2]), int'(data[11:2]));
            compare_field("led_closed", int'(exp_word[12]), int'(data[12]));
            compare_field("led_open", int'(exp_word[13]), int'(data[13]));
            compare_field("led_manual", int'(exp_word[14]), int'(data[14]));
            compare_field("manual_mode", int'(exp_word[15]), int'(data[15]));
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [15:0]           s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [15:0]           m_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    curtain_tracker tracker;
    int  cycle_count = 0;
    int  words_sent = 0;
    int  reg_writes = 0;
    int  settings_run = 0;
    bit  no_idle = 1'b0;

    curtain_motor_controller u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        if (no_idle)
            m_tready <= 1'b1;
        else
            m_tready <= ($urandom_range(99) >= 23);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            tracker.check_word(m_tdata);
    end

    function automatic logic [15:0] poll_word(logic [LIGHT_W-1:0] light, logic mode_b,
                                              logic sw_closed, logic sw_middle, logic sw_open,
                                              logic b_close, logic b_open);
        return {b_open, b_close, sw_open, sw_middle, sw_closed, mode_b, light};
    endfunction

    // Called at a falling edge; returns at the falling edge after the word is taken.
    task automatic send_word(input logic op, input logic [15:0] data);
        if (!no_idle) begin
            while ($urandom_range(99) < 23) begin
                s_tvalid <= 1'b0;
                @(negedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= data;
        do
            @(posedge clk);
        while (!s_tready);
        tracker.take_word(op, data);
        words_sent++;
        @(negedge clk);
    endtask

    task automatic send_poll(input logic [LIGHT_W-1:0] light, input logic mode_b,
                             input logic sw_closed, input logic sw_middle, input logic sw_open,
                             input logic b_close, input logic b_open);
        send_word(1'b0, poll_word(light, mode_b, sw_closed, sw_middle, sw_open, b_close, b_open));
    endtask

    task automatic send_tick();
        send_word(1'b1, 16'($urandom));
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        tracker.write_reg(idx, data);
        reg_writes++;
        @(negedge clk);
    endtask

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (tracker.pending() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic load_settings(input logic [CFG_DATA_W-1:0] open_thr,
                                 input logic [CFG_DATA_W-1:0] close_thr,
                                 input logic [CFG_DATA_W-1:0] full_d,
                                 input logic [CFG_DATA_W-1:0] slow_d,
                                 input logic [CFG_DATA_W-1:0] mid_d);
        write_reg(CFG_OPEN_THR, open_thr);
        write_reg(CFG_CLOSE_THR, close_thr);
        write_reg(CFG_FULL_DUTY, full_d);
        write_reg(CFG_SLOW_DUTY, slow_d);
        write_reg(CFG_MID_DUTY, mid_d);
        // Indexes past the last register must leave every register alone.
        write_reg(CFG_IDX_W'(CFG_LAST + 1 + $urandom_range(2)), CFG_DATA_W'($urandom));
        cfg_valid <= 1'b0;
        settings_run++;
    endtask

    // A full move: start it, let the LED blink, maybe pass the middle mark, then hit the
    // limit switch in the direction of travel, or random end switches if no move started.
    task automatic run_trip();
        logic [LIGHT_W-1:0] light;
        logic [1:0]         dir;
        case ($urandom_range(2))
            0: light = '0;
            1: light = '1;
            default: light = LIGHT_W'($urandom);
        endcase
        send_poll(light, $urandom_range(19) == 0, 1'b0, 1'b0, 1'b0,
                  $urandom_range(9) < 7, $urandom_range(9) < 7);
        repeat ($urandom_range(3)) send_tick();
        if ($urandom_range(1))
            send_poll(LIGHT_W'($urandom), 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
        repeat ($urandom_range(2)) send_tick();
        dir = tracker.current_drive();
        if (dir == DIR_CLOSE)
            send_poll(LIGHT_W'($urandom), 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
        else if (dir == DIR_OPEN)
            send_poll(LIGHT_W'($urandom), 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0);
        else
            send_poll(LIGHT_W'($urandom), 1'b0, 1'($urandom_range(1)), 1'b0,
                      1'($urandom_range(1)), 1'b0, 1'b0);
    endtask

    task automatic send_noise();
        if ($urandom_range(3) == 0)
            send_tick();
        else
            send_word(1'b0, 16'($urandom));
    endtask

    initial
    begin
        int phase_start;
        bit held;
        tracker = new();
        held = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tuser = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part under the reset settings; the open threshold is out of reach here.
        s_tuser <= 1'b1;
        send_word(1'b1, 16'hFFFF);
        send_poll(10'd1023, 0, 0, 0, 0, 0, 0);
        send_poll(10'd0, 0, 0, 0, 1, 0, 0);        // open switch while stopped, then close
        send_tick();
        send_tick();
        send_poll(10'd1023, 0, 0, 0, 1, 0, 0);     // open switch while moving away
        send_poll(10'd512, 0, 0, 1, 0, 0, 0);
        send_tick();
        send_poll(10'd0, 0, 1, 0, 0, 0, 0);        // closed end reached
        send_poll(10'd1023, 0, 0, 0, 0, 0, 0);     // auto open cannot fire
        send_poll(10'd1023, 1, 0, 0, 0, 0, 0);     // into manual mode
        send_poll(10'd0, 0, 0, 0, 0, 1, 1);        // both buttons while closed: opens
        send_poll(10'd0, 0, 0, 1, 0, 0, 0);
        send_tick();
        send_poll(10'd0, 0, 0, 0, 1, 0, 0);        // open end reached
        send_poll(10'd1023, 0, 0, 0, 0, 1, 1);     // both buttons while open: closes
        send_poll(10'd0, 0, 1, 1, 1, 0, 0);        // halt then middle mark while stopped
        send_poll(10'd0, 0, 0, 0, 0, 0, 1);        // opens at slow duty
        send_tick();
        send_poll(10'd1023, 1, 1, 1, 1, 1, 1);     // everything pressed at once
        send_tick();
        wait_drain();

        // Both thresholds satisfied at once: auto mode closes from the open end.
        load_settings(11'd0, 11'd2047, 11'd1023, 11'd0, 11'd1023);
        send_poll(10'd1023, 0, 1, 0, 0, 0, 0);
        send_poll(10'd0, 0, 0, 0, 1, 0, 0);
        send_poll(10'd1023, 0, 0, 0, 0, 0, 0);
        send_tick();
        wait_drain();

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: load_settings(11'd1023, 11'd1023, 11'd1023, 11'd1023, 11'd1023);
                1: load_settings(11'd2047, 11'd0, 11'h400, 11'h7FF, 11'h400);
                2: load_settings(11'd0, 11'd2047, 11'd0, 11'd0, 11'd0);
                default: load_settings(CFG_DATA_W'($urandom_range(1100)),
                                       CFG_DATA_W'($urandom_range(1100)),
                                       CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                                       CFG_DATA_W'($urandom));
            endcase
            no_idle = (phase == 3);
            phase_start = words_sent;
            while (words_sent - phase_start < PHASE_WORDS) begin
                if ($urandom_range(9) < 7)
                    run_trip();
                else
                    send_noise();
                // Hold off once mid-run until every owed word has come back.
                if (phase == 4 && !held && words_sent - phase_start >= PHASE_WORDS / 2) begin
                    wait_drain();
                    held = 1'b1;
                end
            end
            wait_drain();
            no_idle = 1'b0;
        end

        $display("Covered %0d input words and %0d result words under %0d register settings",
                 words_sent, tracker.results_seen, settings_run);
        $display("(%0d register writes, including ignored indexes and masked upper bits).",
                 reg_writes);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
